>>> hw/rtl/tsim_pkg.sv
// Tour swap/inversion mutation: shared types and constants.
// Used by tour_swap_invert_mutation; no dependencies.
`default_nettype none
package tsim_pkg;

  localparam int MAX_CITIES = 1024;
  localparam int POS_W      = $clog2(MAX_CITIES);
  localparam int CITY_W     = 10;
  localparam int LEN_W      = 11;
  localparam int THR_W      = 17;
  localparam int PROB_W     = 16;
  localparam int RAND_W     = 64;
  localparam int CNT_W      = $clog2(RAND_W);
  localparam int CFG_IDX_W  = 2;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CITIES);
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [THR_W-1:0] THR_RESET = 17'd65536;
  localparam logic [LEN_W-1:0] LEN_MIN   = 11'd2;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_MUTATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd2;

  localparam logic MODE_SWAP   = 1'b0;
  localparam logic MODE_INVERT = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  position;
    logic [CITY_W-1:0] city_in;
    logic [PROB_W-1:0] rand_prob;
    logic [RAND_W-1:0] rand_first;
    logic [RAND_W-1:0] rand_second;
  } in_req_t;

  typedef struct packed {
    logic [CITY_W-1:0] city_out;
    logic              status;
    logic              mutated;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  second_pos;
  } out_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/tsim_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsim_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/tour_swap_invert_mutation.sv
// Tour store with swap / segment-inversion mutation, top level.
// Depends on tsim_pkg and tsim_ram.
//
//  port group  | dir | handshake         | content
//  in_*        | in  | in_valid/in_stall | in_req_t: command, position, city, draws
//  out_*       | out | out_valid/out_stall | out_rsp_t: city, status, mutated, positions
//  cfg_*       | in  | cfg_we            | register index and write data
//
// A write or unused command goes straight to the output state; a read first
// waits for the RAM read data. A fired mutation reduces both 64-bit draws in
// the bit-serial modulo unit, orders the positions, then reads and writes each
// exchanged pair in the tour RAM: one for a swap, up to 512 for a 1024-entry tour.
// One request at a time: in_stall is high while a request is in work.
// Reset is synchronous; the tour RAM is not cleared.
`default_nettype none
module tour_swap_invert_mutation (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tsim_pkg::in_req_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tsim_pkg::out_rsp_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tsim_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [tsim_pkg::THR_W-1:0]        cfg_wdata
);
  import tsim_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_MOD, ST_ADJ, ST_RDL, ST_RDR, ST_WRL, ST_WRR, ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [THR_W-1:0]  thr_r;
  logic              mode_r;
  out_rsp_t          res_r, res_nxt;
  out_rsp_t          out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RAND_W-1:0] src_r, src_nxt;
  logic [RAND_W-1:0] r2_r, r2_nxt;
  logic [POS_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sec_r, sec_nxt;
  logic [POS_W-1:0]  l_r, l_nxt;
  logic [POS_W-1:0]  r_r, r_nxt;
  logic [CITY_W-1:0] hold_r, hold_nxt;

  logic [LEN_W-1:0]  n_eff;
  logic [LEN_W-1:0]  trial;
  logic [POS_W-1:0]  trial_rem;
  logic              accept;

  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [CITY_W-1:0] ram_wdata;
  logic [POS_W-1:0]  ram_raddr;
  logic [CITY_W-1:0] ram_rdata;

  tsim_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_eff     = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  // one restoring step: remainder stays below the divisor (at most 1024)
  assign trial     = {rem_r, src_r[RAND_W-1]};
  assign trial_rem = (trial >= div_r) ? POS_W'(trial - div_r) : POS_W'(trial);

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    src_nxt       = src_r;
    r2_nxt        = r2_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    sec_nxt       = sec_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    hold_nxt      = hold_r;
    ram_we        = 1'b0;
    ram_waddr     = l_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = l_r;

    case (state_r)
      ST_IDLE: begin
        ram_raddr = in_data.position;
        ram_waddr = in_data.position;
        ram_wdata = in_data.city_in;
        if (accept) begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
          case (in_data.cmd)
            CMD_WRITE: ram_we = 1'b1;
            CMD_READ:  state_nxt = ST_RD_WAIT;
            CMD_MUTATE: begin
              if (THR_W'(in_data.rand_prob) <= thr_r) begin
                if (n_eff < LEN_MIN) begin
                  res_nxt.status = 1'b1;
                end else begin
                  src_nxt   = in_data.rand_first;
                  r2_nxt    = in_data.rand_second;
                  rem_nxt   = '0;
                  cnt_nxt   = '0;
                  sec_nxt   = 1'b0;
                  div_nxt   = n_eff;
                  state_nxt = ST_MOD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        res_nxt.city_out = ram_rdata;
        state_nxt        = ST_OUT;
      end
      ST_MOD: begin
        rem_nxt = trial_rem;
        src_nxt = {src_r[RAND_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RAND_W - 1)) begin
          if (!sec_r) begin
            l_nxt   = trial_rem;
            src_nxt = r2_r;
            rem_nxt = '0;
            sec_nxt = 1'b1;
            div_nxt = (mode_r == MODE_SWAP) ? n_eff - 1'b1 : n_eff;
          end else begin
            r_nxt     = trial_rem;
            state_nxt = ST_ADJ;
          end
        end
      end
      ST_ADJ: begin
        res_nxt.mutated = 1'b1;
        if (mode_r == MODE_SWAP) begin
          // second draw skips over the first position
          if (r_r >= l_r) begin
            r_nxt = r_r + 1'b1;
          end
          res_nxt.first_pos  = l_r;
          res_nxt.second_pos = (r_r >= l_r) ? r_r + 1'b1 : r_r;
          state_nxt          = ST_RDL;
        end else begin
          if (l_r > r_r) begin
            l_nxt = r_r;
            r_nxt = l_r;
          end
          res_nxt.first_pos  = (l_r > r_r) ? r_r : l_r;
          res_nxt.second_pos = (l_r > r_r) ? l_r : r_r;
          state_nxt          = (l_r != r_r) ? ST_RDL : ST_OUT;
        end
      end
      ST_RDL: begin
        ram_raddr = l_r;
        state_nxt = ST_RDR;
      end
      ST_RDR: begin
        ram_raddr = r_r;
        hold_nxt  = ram_rdata;
        state_nxt = ST_WRL;
      end
      ST_WRL: begin
        ram_we    = 1'b1;
        ram_waddr = l_r;
        ram_wdata = ram_rdata;
        state_nxt = ST_WRR;
      end
      ST_WRR: begin
        ram_we    = 1'b1;
        ram_waddr = r_r;
        ram_wdata = hold_r;
        l_nxt     = l_r + 1'b1;
        r_nxt     = r_r - 1'b1;
        if ((mode_r == MODE_INVERT) && ((l_r + 1'b1) < (r_r - 1'b1))) begin
          state_nxt = ST_RDL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= LEN_RESET;
      thr_r       <= THR_RESET;
      mode_r      <= MODE_SWAP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TOUR_LENGTH: len_r  <= cfg_wdata[LEN_W-1:0];
          CFG_THRESHOLD:   thr_r  <= cfg_wdata;
          CFG_MODE:        mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    src_r      <= src_nxt;
    r2_r       <= r2_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    sec_r      <= sec_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    hold_r     <= hold_nxt;
  end

  // remainder stays reduced during the modulo steps
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (LEN_W'(rem_r) < div_r))
    else $error("modulo remainder not below divisor");

  // reversal only ever works on an ordered pair
  a_invert_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RDL) && (mode_r == MODE_INVERT)) |-> (l_r < r_r))
    else $error("inversion pointers crossed");

  // swap never exchanges an entry with itself
  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RDL) && (mode_r == MODE_SWAP)) |-> (l_r != r_r))
    else $error("swap positions equal");

  // an invalid-length result carries no mutation and no positions
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (!out_data.mutated && (out_data.first_pos == '0) && (out_data.second_pos == '0)))
    else $error("invalid-length result with mutation data");

  // positions reported for a mutation lie inside the tour
  a_pos_in_tour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mutated) |->
      ((LEN_W'(out_data.first_pos) < n_eff) && (LEN_W'(out_data.second_pos) < n_eff)))
    else $error("mutation position outside tour");

endmodule
`default_nettype wire
